// ----- sv/assert_macros.svh -----
// assertion macros shared by the hard-iron calibration rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MHI_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mhi assertion failed");
`define MHI_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("mhi assertion failed");
`else
`define MHI_ASSERT(name, prop)
`define MHI_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ----- sv/mhi_pkg.sv -----
// types, constants and saturating helpers for the hard-iron calibration block
package mhi_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 24;
    localparam int COMP_BITS   = SAMPLE_BITS + 2;
    localparam int LAMBDA_BITS = 17;
    localparam int LIMIT_BITS  = 25;
    localparam int TMO_BITS    = 16;
    localparam int CFG_BITS    = 25;

    typedef logic signed [63:0]          q64_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COMP_BITS-1:0]   comp_t;
    typedef logic signed [31:0]          bias_t;
    typedef logic [1:0]                  cmd_t;
    typedef logic [1:0]                  cfg_index_t;
    typedef logic [CFG_BITS-1:0]         cfg_data_t;

    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_START  = 2'd1;
    localparam cmd_t CMD_TICK   = 2'd2;

    localparam cfg_index_t REG_LAMBDA  = 2'd0;
    localparam cfg_index_t REG_LIMIT   = 2'd1;
    localparam cfg_index_t REG_TIMEOUT = 2'd2;

    localparam logic [LAMBDA_BITS-1:0] LAMBDA_RESET  = 17'd65208;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET   = 25'd16777;
    localparam logic [TMO_BITS-1:0]    TIMEOUT_RESET = 16'd10000;

    localparam q64_t Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q64_t Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam q64_t Q_ONE  = q64_t'(1) <<< FRAC_BITS;
    localparam q64_t P_INIT = q64_t'(1000) <<< FRAC_BITS;

    typedef struct packed {
        logic done;
        logic conv;
    } rls_status_t;

    // saturating 64-bit add or subtract
    function automatic q64_t sat_add(input q64_t a, input q64_t b, input logic sub);
        logic signed [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63])
            return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    // signed result from magnitude and sign, clamped to 64 bits
    function automatic q64_t sat_sign(input logic [63:0] q, input logic neg, input logic ovf);
        if (!neg)
            return (ovf || q[63]) ? Q_MAX : q64_t'(q);
        if (ovf || q[63])
            return Q_MIN;
        return q64_t'(~q + 64'd1);
    endfunction

endpackage

// ----- sv/mhi_chan_if.sv -----
// valid/ready channel interfaces for sample items and result items
interface mhi_in_if;
    import mhi_pkg::*;
    logic    valid;
    logic    ready;
    cmd_t    cmd;
    sample_t mag_x;
    sample_t mag_y;
    sample_t mag_z;
    modport source (output valid, cmd, mag_x, mag_y, mag_z, input ready);
    modport sink (input valid, cmd, mag_x, mag_y, mag_z, output ready);
endinterface

interface mhi_out_if;
    import mhi_pkg::*;
    logic  valid;
    logic  ready;
    comp_t comp_x;
    comp_t comp_y;
    comp_t comp_z;
    logic  sample_valid;
    logic  calibrating;
    logic  calib_done;
    logic  calib_timeout;
    modport source (output valid, comp_x, comp_y, comp_z, sample_valid, calibrating,
                    calib_done, calib_timeout, input ready);
    modport sink (input valid, comp_x, comp_y, comp_z, sample_valid, calibrating,
                  calib_done, calib_timeout, output ready);
endinterface

// ----- sv/mhi_mul.sv -----
// fixed-point multiplier built from four 32x32 partial products
module mhi_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mhi_pkg::q64_t a,
    input  mhi_pkg::q64_t b,
    output logic          done,
    output mhi_pkg::q64_t p
);
    import mhi_pkg::*;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         neg_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sel_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    q64_t         p_reg;

    logic [63:0]  ma_w;
    logic [63:0]  mb_w;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp_w;
    logic [127:0] pp_shift;
    logic [63:0]  q_w;
    logic [63:0]  q_inc;
    logic         ovf_w;
    logic         rem_w;
    q64_t         res_w;

    assign ma_w   = a[63] ? (~a + 64'd1) : a;
    assign mb_w   = b[63] ? (~b + 64'd1) : b;
    assign a_half = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_half = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_w   = a_half * b_half;

    always_comb
    begin
        case (sel_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // floor shift of the product, negative results round toward minus infinity
    always_comb
    begin
        q_w   = acc_reg[FRAC_BITS +: 64];
        ovf_w = |acc_reg[127:FRAC_BITS+64];
        rem_w = |acc_reg[FRAC_BITS-1:0];
        q_inc = q_w;
        if (neg_reg && rem_w)
        begin
            if (&q_w)
                ovf_w = 1'b1;
            else
                q_inc = q_w + 64'd1;
        end
        res_w = sat_sign(q_inc, neg_reg, ovf_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
                acc_reg  <= '0;
                neg_reg  <= a[63] ^ b[63];
                ma_reg   <= ma_w;
                mb_reg   <= mb_w;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg < 3'd4)
                begin
                    pp_reg  <= pp_w;
                    sel_reg <= cnt_reg[1:0];
                end
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                    acc_reg <= acc_reg + pp_shift;
                if (cnt_reg == 3'd5)
                begin
                    p_reg    <= res_w;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ----- sv/mhi_div.sv -----
// fixed-point divider, restoring, one quotient bit per cycle
module mhi_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mhi_pkg::q64_t a,
    input  mhi_pkg::q64_t b,
    output logic          done,
    output mhi_pkg::q64_t q
);
    import mhi_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] q_reg;
    logic [63:0] mb_reg;
    logic        neg_reg;
    logic        spec_reg;
    logic        done_reg;
    q64_t        p_reg;

    logic [63:0] ma_w;
    logic [63:0] mb_w;
    logic [63:0] hi_w;
    logic [64:0] r65;
    logic [64:0] diff;
    logic        ge;

    assign ma_w = a[63] ? (~a + 64'd1) : a;
    assign mb_w = b[63] ? (~b + 64'd1) : b;
    assign hi_w = ma_w >> (64 - FRAC_BITS);
    assign r65  = {rem_reg, lo_reg[63]};
    assign diff = r65 - {1'b0, mb_reg};
    assign ge   = r65 >= {1'b0, mb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= 6'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg <= a[63] ^ b[63];
                        mb_reg  <= mb_w;
                        if (b == '0)
                        begin
                            spec_reg  <= 1'b1;
                            p_reg     <= (a == '0) ? '0 : (a[63] ? Q_MIN : Q_MAX);
                            state_reg <= D_FIN;
                        end
                        else if (hi_w >= mb_w)
                        begin
                            spec_reg  <= 1'b1;
                            p_reg     <= (a[63] ^ b[63]) ? Q_MIN : Q_MAX;
                            state_reg <= D_FIN;
                        end
                        else
                        begin
                            spec_reg  <= 1'b0;
                            rem_reg   <= hi_w;
                            lo_reg    <= ma_w << FRAC_BITS;
                            q_reg     <= '0;
                            cnt_reg   <= 6'd0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? diff[63:0] : r65[63:0];
                    q_reg   <= {q_reg[62:0], ge};
                    lo_reg  <= lo_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (&cnt_reg)
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    if (!spec_reg)
                        p_reg <= sat_sign(q_reg, neg_reg, 1'b0);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign q    = p_reg;

endmodule

// ----- sv/mhi_rls.sv -----
// rls sphere-fit sequencer driving the shared multiplier, divider and adder
`include "assert_macros.svh"
module mhi_rls (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mhi_pkg::comp_t       comp [3],
    input  logic [16:0]          lambda,
    input  logic [24:0]          limit,
    output mhi_pkg::rls_status_t status,
    output mhi_pkg::q64_t        theta [3]
);
    import mhi_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MWAIT, S_LAM, S_DIV, S_DWAIT, S_FIN} state_t;
    typedef enum logic [3:0] {PH_Y, PH_ERR, PH_PX, PH_XP, PH_S, PH_G, PH_P, PH_TH,
                              PH_E} phase_t;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [1:0] i_reg;
    logic [1:0] j_reg;
    q64_t       acc_reg;
    q64_t       err_reg;
    q64_t       s_reg;
    q64_t       t_reg;
    logic       conv_reg;
    logic       done_reg;
    q64_t       theta_reg [4];
    q64_t       p_reg [16];
    q64_t       px_reg [4];
    q64_t       xp_reg [4];
    q64_t       g_reg [4];

    q64_t       lam;
    q64_t       lim;
    logic [1:0] x_idx;
    q64_t       x_val;
    logic [3:0] p_addr;
    q64_t       p_val;
    q64_t       mul_a;
    q64_t       mul_b;
    logic       mul_done;
    q64_t       mul_p;
    q64_t       div_a;
    q64_t       div_b;
    logic       div_done;
    q64_t       div_q;
    q64_t       add_a;
    q64_t       add_b;
    logic       add_sub;
    q64_t       add_res;
    logic       first;
    logic       last_i;
    logic       last_j;

    assign lam    = q64_t'(lambda) <<< (FRAC_BITS - 16);
    assign lim    = q64_t'(limit) <<< (FRAC_BITS - 24);
    assign last_i = (i_reg == 2'd3);
    assign last_j = (j_reg == 2'd3);
    assign first  = (phase_reg == PH_PX || phase_reg == PH_XP) ? (j_reg == 2'd0)
                                                               : (i_reg == 2'd0);

    // regressor element: compensated axes then the constant one
    always_comb
    begin
        x_idx = (phase_reg == PH_PX || phase_reg == PH_XP) ? j_reg : i_reg;
        case (x_idx)
            2'd0:    x_val = q64_t'(comp[0]) <<< FRAC_BITS;
            2'd1:    x_val = q64_t'(comp[1]) <<< FRAC_BITS;
            2'd2:    x_val = q64_t'(comp[2]) <<< FRAC_BITS;
            default: x_val = Q_ONE;
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_XP:   p_addr = {j_reg, i_reg};
            PH_E:    p_addr = {i_reg, i_reg};
            default: p_addr = {i_reg, j_reg};
        endcase
    end
    assign p_val = p_reg[p_addr];

    always_comb
    begin
        case (phase_reg)
            PH_Y:    begin mul_a = x_val;          mul_b = x_val;          end
            PH_ERR:  begin mul_a = x_val;          mul_b = theta_reg[i_reg]; end
            PH_PX:   begin mul_a = p_val;          mul_b = x_val;          end
            PH_XP:   begin mul_a = x_val;          mul_b = p_val;          end
            PH_S:    begin mul_a = x_val;          mul_b = px_reg[i_reg];  end
            PH_P:    begin mul_a = g_reg[i_reg];   mul_b = xp_reg[j_reg];  end
            PH_TH:   begin mul_a = err_reg;        mul_b = g_reg[i_reg];   end
            default: begin mul_a = p_val;          mul_b = p_val;          end
        endcase
    end

    assign div_a = (phase_reg == PH_G) ? px_reg[i_reg] : t_reg;
    assign div_b = (phase_reg == PH_G) ? s_reg : lam;

    always_comb
    begin
        add_a   = first ? '0 : acc_reg;
        add_b   = mul_p;
        add_sub = 1'b0;
        if (state_reg == S_LAM)
        begin
            add_a = lam;
            add_b = acc_reg;
        end
        else
        begin
            case (phase_reg)
                PH_Y:    add_a = acc_reg;
                PH_ERR:  begin add_a = acc_reg; add_sub = 1'b1; end
                PH_P:    begin add_a = p_val;   add_sub = 1'b1; end
                PH_TH:   add_a = theta_reg[i_reg];
                default: ;
            endcase
        end
        add_res = sat_add(add_a, add_b, add_sub);
    end

    mhi_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_MUL),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    mhi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIV),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_Y;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            conv_reg  <= 1'b0;
            done_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
                theta_reg[k] <= '0;
            for (int k = 0; k < 16; k++)
                p_reg[k] <= (k % 5 == 0) ? P_INIT : '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_Y;
                        i_reg     <= 2'd0;
                        j_reg     <= 2'd0;
                        acc_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MUL;
                        unique case (phase_reg)
                            PH_Y:
                            begin
                                acc_reg <= add_res;
                                i_reg   <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                                if (i_reg == 2'd2)
                                    phase_reg <= PH_ERR;
                            end
                            PH_ERR:
                            begin
                                acc_reg <= add_res;
                                i_reg   <= i_reg + 2'd1;
                                if (last_i)
                                begin
                                    err_reg   <= add_res;
                                    phase_reg <= PH_PX;
                                    j_reg     <= 2'd0;
                                end
                            end
                            PH_PX, PH_XP:
                            begin
                                acc_reg <= add_res;
                                j_reg   <= j_reg + 2'd1;
                                if (last_j)
                                begin
                                    if (phase_reg == PH_PX)
                                        px_reg[i_reg] <= add_res;
                                    else
                                        xp_reg[i_reg] <= add_res;
                                    i_reg <= i_reg + 2'd1;
                                    if (last_i)
                                        phase_reg <= (phase_reg == PH_PX) ? PH_XP : PH_S;
                                end
                            end
                            PH_S:
                            begin
                                acc_reg <= add_res;
                                i_reg   <= i_reg + 2'd1;
                                if (last_i)
                                    state_reg <= S_LAM;
                            end
                            PH_P:
                            begin
                                t_reg     <= add_res;
                                state_reg <= S_DIV;
                            end
                            PH_TH:
                            begin
                                theta_reg[i_reg] <= add_res;
                                i_reg            <= i_reg + 2'd1;
                                if (last_i)
                                    phase_reg <= PH_E;
                            end
                            PH_E:
                            begin
                                acc_reg <= add_res;
                                i_reg   <= i_reg + 2'd1;
                                if (last_i)
                                begin
                                    conv_reg  <= add_res < lim;
                                    state_reg <= S_FIN;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_LAM:
                begin
                    s_reg     <= add_res;
                    phase_reg <= PH_G;
                    i_reg     <= 2'd0;
                    state_reg <= S_DIV;
                end
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (phase_reg == PH_G)
                        begin
                            g_reg[i_reg] <= div_q;
                            i_reg        <= i_reg + 2'd1;
                            if (last_i)
                            begin
                                phase_reg <= PH_P;
                                j_reg     <= 2'd0;
                                state_reg <= S_MUL;
                            end
                            else
                                state_reg <= S_DIV;
                        end
                        else
                        begin
                            p_reg[p_addr] <= div_q;
                            j_reg         <= j_reg + 2'd1;
                            state_reg     <= S_MUL;
                            if (last_j)
                            begin
                                i_reg <= i_reg + 2'd1;
                                if (last_i)
                                    phase_reg <= PH_TH;
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign status.done = done_reg;
    assign status.conv = conv_reg;
    assign theta[0]    = theta_reg[0];
    assign theta[1]    = theta_reg[1];
    assign theta[2]    = theta_reg[2];

    `MHI_ASSERT(a_start_idle, start |-> state_reg == S_IDLE)
    `MHI_ASSERT(a_mul_done_wait, mul_done |-> state_reg == S_MWAIT)
    `MHI_ASSERT(a_div_done_wait, div_done |-> state_reg == S_DWAIT)
    `MHI_ASSERT(a_done_after_fin, done_reg |-> $past(state_reg) == S_FIN)

endmodule

// ----- sv/mag_hard_iron_rls_calibration.sv -----
// Magnetometer hard-iron compensation with an RLS sphere-fit calibration.
// in_ch carries one command beat: a sample, a start of calibration or a
// one-millisecond tick. out_ch returns exactly one result beat per command
// with the compensated body-frame vector (x = -mag_y, y = mag_x,
// z = mag_z, minus the stored bias, saturated to 18 bits) and flags.
// For ticks, starts and samples outside calibration the result is registered
// on the accepting edge, and while out_ch is ready a new beat can follow every
// cycle. A sample during calibration runs one RLS step on a shared 64-bit
// multiplier (67 products) and a shared bit-serial divider (20 quotients);
// in_ch.ready stays low while the step runs. Configuration writes go through
// cfg_wr_en/cfg_index/cfg_wr_data; the user makes them only while idle,
// which the block itself does not enforce.
// Reset clears the bias, fit parameters and timer, loads the covariance with
// 1000 on its diagonal and restores the register defaults.
// When out_ch stalls the result is held, and a new command is taken only in
// the cycle in which the held result is taken.
`include "assert_macros.svh"
module mag_hard_iron_rls_calibration (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  mhi_pkg::cfg_index_t cfg_index,
    input  mhi_pkg::cfg_data_t  cfg_wr_data,
    mhi_in_if.sink              in_ch,
    mhi_out_if.source           out_ch
);
    import mhi_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                  state_reg;
    logic [LAMBDA_BITS-1:0]  lambda_reg;
    logic [LIMIT_BITS-1:0]   limit_reg;
    logic [TMO_BITS-1:0]     timeout_reg;
    bias_t                   bias_reg [3];
    comp_t                   comp_reg [3];
    logic                    calib_reg;
    logic [TMO_BITS-1:0]     elapsed_reg;
    logic                    start_reg;
    logic                    out_valid_reg;
    logic                    sample_valid_reg;
    logic                    done_reg;
    logic                    tmo_reg;

    logic                    accept;
    logic signed [SAMPLE_BITS:0] raw [3];
    comp_t                   comp_new [3];
    bias_t                   bias_new [3];
    rls_status_t             rls_st;
    q64_t                    theta_w [3];

    assign accept = in_ch.valid && in_ch.ready;
    assign raw[0] = -(SAMPLE_BITS+1)'(in_ch.mag_y);
    assign raw[1] = (SAMPLE_BITS+1)'(in_ch.mag_x);
    assign raw[2] = (SAMPLE_BITS+1)'(in_ch.mag_z);

    always_comb
    begin
        logic signed [33:0] d;
        q64_t h;
        for (int k = 0; k < 3; k++)
        begin
            d = 34'(raw[k]) - 34'(bias_reg[k]);
            if (d > 34'sd131071)
                comp_new[k] = comp_t'(34'sd131071);
            else if (d < -34'sd131072)
                comp_new[k] = comp_t'(-34'sd131072);
            else
                comp_new[k] = d[COMP_BITS-1:0];
            // round half of theta to whole counts
            h = sat_add(theta_w[k], Q_ONE, 1'b0) >>> (FRAC_BITS + 1);
            if (h > 64'sh7FFF_FFFF)
                bias_new[k] = 32'sh7FFF_FFFF;
            else if (h < -64'sh8000_0000)
                bias_new[k] = 32'sh8000_0000;
            else
                bias_new[k] = h[31:0];
        end
    end

    mhi_rls u_rls (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .comp   (comp_reg),
        .lambda (lambda_reg),
        .limit  (limit_reg),
        .status (rls_st),
        .theta  (theta_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lambda_reg       <= LAMBDA_RESET;
            limit_reg        <= LIMIT_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            calib_reg        <= 1'b0;
            elapsed_reg      <= '0;
            start_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            sample_valid_reg <= 1'b0;
            done_reg         <= 1'b0;
            tmo_reg          <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                bias_reg[k] <= '0;
                comp_reg[k] <= '0;
            end
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_LAMBDA:  lambda_reg  <= cfg_wr_data[LAMBDA_BITS-1:0];
                    REG_LIMIT:   limit_reg   <= cfg_wr_data[LIMIT_BITS-1:0];
                    REG_TIMEOUT: timeout_reg <= cfg_wr_data[TMO_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_valid_reg    <= 1'b1;
                        sample_valid_reg <= (in_ch.cmd == CMD_SAMPLE);
                        done_reg         <= 1'b0;
                        tmo_reg          <= 1'b0;
                        case (in_ch.cmd)
                            CMD_SAMPLE:
                            begin
                                comp_reg <= comp_new;
                                if (calib_reg)
                                begin
                                    out_valid_reg <= 1'b0;
                                    start_reg     <= 1'b1;
                                    state_reg     <= S_RUN;
                                end
                            end
                            CMD_START:
                            begin
                                calib_reg   <= 1'b1;
                                elapsed_reg <= '0;
                            end
                            CMD_TICK:
                            begin
                                if (calib_reg && !(&elapsed_reg))
                                    elapsed_reg <= elapsed_reg + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN:
                begin
                    if (rls_st.done)
                    begin
                        out_valid_reg <= 1'b1;
                        done_reg      <= 1'b0;
                        tmo_reg       <= 1'b0;
                        if (rls_st.conv)
                        begin
                            bias_reg  <= bias_new;
                            calib_reg <= 1'b0;
                            done_reg  <= 1'b1;
                        end
                        else if (elapsed_reg > timeout_reg)
                        begin
                            calib_reg <= 1'b0;
                            tmo_reg   <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready          = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.comp_x        = comp_reg[0];
    assign out_ch.comp_y        = comp_reg[1];
    assign out_ch.comp_z        = comp_reg[2];
    assign out_ch.sample_valid  = sample_valid_reg;
    assign out_ch.calibrating   = calib_reg;
    assign out_ch.calib_done    = done_reg;
    assign out_ch.calib_timeout = tmo_reg;

    `MHI_ASSERT_ALWAYS(a_ready_idle, in_ch.ready |-> state_reg == S_IDLE)
    `MHI_ASSERT(a_flags_excl, out_valid_reg |-> !(done_reg && tmo_reg))
    `MHI_ASSERT(a_rls_done_run, rls_st.done |-> state_reg == S_RUN)
    `MHI_ASSERT(a_end_calib, (out_valid_reg && (done_reg || tmo_reg)) |-> !calib_reg)
    `MHI_ASSERT(a_flags_sample, (out_valid_reg && !sample_valid_reg) |-> !(done_reg || tmo_reg))

endmodule
